// ----- design/fixed_to_decimal_text_core_macros.svh -----
// Assertion macros for the fixed-to-decimal text core checker.
// No dependencies; expects clk_i and rst_ni in the scope of each use.
`ifndef FIXED_TO_DECIMAL_TEXT_CORE_MACROS_SVH
`define FIXED_TO_DECIMAL_TEXT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define F2D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("f2d check failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define F2D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("f2d check failed");

`endif

// ----- design/f2d_pkg.sv -----
// Package for the fixed-to-decimal text core: constants, control types.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps

package f2d_pkg;

  localparam int DEF_FRAC_BITS           = 16;
  localparam int DEF_INT_BITS            = 32;
  localparam int DEF_MAX_FRACTION_DIGITS = 15;

  localparam int CFG_W  = 4;
  localparam int CHAR_W = 8;

  localparam logic [CFG_W-1:0]  CFG_RESET  = 4'd2;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Number of decimal digits of the largest unsigned value of the given width.
  function automatic int dec_digits(input int bits);
    longint unsigned v;
    int              n;
    v = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    n = 1;
    for (int k = 0; k < 20; k++) begin
      if (v >= 64'd10) begin
        v = v / 64'd10;
        n = n + 1;
      end
    end
    return n;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FRAC
  } f2d_state_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_sign;
    logic int_step;
    logic emit_dot;
    logic frac_step;
  } f2d_cmd_t;

  typedef struct packed {
    logic neg;
    logic conv_done;
    logic int_last;
    logic frac_none;
    logic frac_last;
    logic push_ok;
  } f2d_sts_t;

endpackage

// ----- design/f2d_datapath.sv -----
// Datapath of the fixed-to-decimal text core: magnitude, double-dabble BCD,
// fraction times-ten unit, digit counters, config register, output word.
// Depends on f2d_pkg.
`timescale 1ns / 1ps

module f2d_datapath #(
  parameter int FRAC_BITS           = f2d_pkg::DEF_FRAC_BITS,
  parameter int INT_BITS            = f2d_pkg::DEF_INT_BITS,
  parameter int MAX_FRACTION_DIGITS = f2d_pkg::DEF_MAX_FRACTION_DIGITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  f2d_pkg::f2d_cmd_t              cmd_i,
  output f2d_pkg::f2d_sts_t              sts_o,
  input  logic [INT_BITS+FRAC_BITS-1:0]  value_i,
  input  logic                           cfg_valid_i,
  input  logic [f2d_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [f2d_pkg::CHAR_W-1:0]     out_char_o,
  output logic                           out_last_o
);

  localparam int TotalBits = INT_BITS + FRAC_BITS;
  localparam int IntDigits = f2d_pkg::dec_digits(INT_BITS);
  localparam int BcdW      = 4 * IntDigits;
  localparam int BitCntW   = $clog2(INT_BITS + 1);
  localparam int DigCntW   = $clog2(IntDigits + 1);
  localparam int CW        = f2d_pkg::CFG_W;

  logic [CW-1:0]        cfg_q, cfg_d;
  logic                 neg_q, neg_d;
  logic [INT_BITS-1:0]  ipart_q, ipart_d;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic [BcdW-1:0]      bcd_q, bcd_d, bcd_adj;
  logic [BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]   dig_cnt_q, dig_cnt_d;
  logic [CW-1:0]        frac_cnt_q, frac_cnt_d;
  logic                 started_q, started_d;
  logic                 out_valid_q, out_valid_d;
  logic [f2d_pkg::CHAR_W-1:0] out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;

  logic [TotalBits-1:0] mag;
  logic [FRAC_BITS+3:0] frac_x10;
  logic [3:0]           int_dig;
  logic                 int_show;
  logic                 emit;
  logic [CW-1:0]        ndig;

  // Magnitude of the two's complement input.
  assign mag = value_i[TotalBits-1] ? (~value_i + TotalBits'(1)) : value_i;

  // Saturate the configured digit count.
  assign ndig = (cfg_q > CW'(MAX_FRACTION_DIGITS)) ? CW'(MAX_FRACTION_DIGITS) : cfg_q;

  // Add 3 to every BCD digit of five or more ahead of the shift.
  always_comb begin
    for (int k = 0; k < IntDigits; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? (bcd_q[4*k +: 4] + 4'd3)
                                                    : bcd_q[4*k +: 4];
    end
  end

  assign frac_x10 = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);
  assign int_dig  = bcd_q[BcdW-1 -: 4];
  // Leading zeros are dropped, but the units digit always shows.
  assign int_show = started_q || (int_dig != 4'd0) || (dig_cnt_q == DigCntW'(1));

  assign emit = cmd_i.emit_sign || cmd_i.emit_dot || cmd_i.frac_step ||
                (cmd_i.int_step && int_show);

  always_comb begin
    cfg_d      = cfg_valid_i ? cfg_data_i : cfg_q;
    neg_d      = neg_q;
    ipart_d    = ipart_q;
    frac_d     = frac_q;
    bcd_d      = bcd_q;
    bit_cnt_d  = bit_cnt_q;
    dig_cnt_d  = dig_cnt_q;
    frac_cnt_d = frac_cnt_q;
    started_d  = started_q;
    out_char_d = out_char_q;
    out_last_d = out_last_q;

    if (cmd_i.load) begin
      neg_d      = value_i[TotalBits-1];
      ipart_d    = mag[TotalBits-1:FRAC_BITS];
      frac_d     = mag[FRAC_BITS-1:0];
      bcd_d      = '0;
      bit_cnt_d  = BitCntW'(INT_BITS);
      dig_cnt_d  = DigCntW'(IntDigits);
      frac_cnt_d = ndig;
      started_d  = 1'b0;
    end

    if (cmd_i.conv_step) begin
      bcd_d     = {bcd_adj[BcdW-2:0], ipart_q[INT_BITS-1]};
      ipart_d   = {ipart_q[INT_BITS-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q - BitCntW'(1);
    end

    if (cmd_i.emit_sign) begin
      out_char_d = f2d_pkg::CHAR_MINUS;
      out_last_d = 1'b0;
    end

    if (cmd_i.int_step) begin
      bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
      dig_cnt_d = dig_cnt_q - DigCntW'(1);
      if (int_show) begin
        started_d  = 1'b1;
        out_char_d = f2d_pkg::CHAR_ZERO + {4'd0, int_dig};
        out_last_d = 1'b0;
      end
    end

    if (cmd_i.emit_dot) begin
      out_char_d = f2d_pkg::CHAR_DOT;
      out_last_d = (frac_cnt_q == '0);
    end

    if (cmd_i.frac_step) begin
      frac_d     = frac_x10[FRAC_BITS-1:0];
      frac_cnt_d = frac_cnt_q - CW'(1);
      out_char_d = f2d_pkg::CHAR_ZERO + {4'd0, frac_x10[FRAC_BITS+3:FRAC_BITS]};
      out_last_d = (frac_cnt_q == CW'(1));
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= f2d_pkg::CFG_RESET;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      frac_cnt_q  <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      frac_cnt_q  <= frac_cnt_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ipart_q    <= ipart_d;
    frac_q     <= frac_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.neg       = neg_q;
  assign sts_o.conv_done = (bit_cnt_q == BitCntW'(1));
  assign sts_o.int_last  = (dig_cnt_q == DigCntW'(1));
  assign sts_o.frac_none = (frac_cnt_q == '0);
  assign sts_o.frac_last = (frac_cnt_q == CW'(1));
  assign sts_o.push_ok   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- design/f2d_ctrl.sv -----
// Controller of the fixed-to-decimal text core: sequences conversion
// and character emission. Depends on f2d_pkg.
`timescale 1ns / 1ps

module f2d_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  f2d_pkg::f2d_sts_t sts_i,
  output f2d_pkg::f2d_cmd_t cmd_o
);

  f2d_pkg::f2d_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      f2d_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = f2d_pkg::ST_CONV;
      end
      f2d_pkg::ST_CONV: begin
        if (sts_i.conv_done) state_d = sts_i.neg ? f2d_pkg::ST_SIGN : f2d_pkg::ST_INT;
      end
      f2d_pkg::ST_SIGN: begin
        if (sts_i.push_ok) state_d = f2d_pkg::ST_INT;
      end
      f2d_pkg::ST_INT: begin
        if (sts_i.push_ok && sts_i.int_last) state_d = f2d_pkg::ST_DOT;
      end
      f2d_pkg::ST_DOT: begin
        if (sts_i.push_ok) state_d = sts_i.frac_none ? f2d_pkg::ST_IDLE : f2d_pkg::ST_FRAC;
      end
      f2d_pkg::ST_FRAC: begin
        if (sts_i.push_ok && sts_i.frac_last) state_d = f2d_pkg::ST_IDLE;
      end
      default: state_d = f2d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      f2d_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      f2d_pkg::ST_CONV: cmd_o.conv_step = 1'b1;
      f2d_pkg::ST_SIGN: cmd_o.emit_sign = sts_i.push_ok;
      f2d_pkg::ST_INT:  cmd_o.int_step  = sts_i.push_ok;
      f2d_pkg::ST_DOT:  cmd_o.emit_dot  = sts_i.push_ok;
      f2d_pkg::ST_FRAC: cmd_o.frac_step = sts_i.push_ok;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= f2d_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/fixed_to_decimal_text_core.sv -----
// Top level of the fixed-to-decimal text core: signed fixed-point in,
// ASCII decimal text out. Depends on f2d_pkg, f2d_ctrl, f2d_datapath.
//
//  channel  | dir | handshake                      | word
//  ---------+-----+--------------------------------+---------------------------------
//  s_axis   | in  | s_axis_tvalid_i/s_axis_tready_o | tdata: value (INT+FRAC bits)
//  m_axis   | out | m_axis_tvalid_o/m_axis_tready_i | tdata: character; tlast: last
//  cfg      | in  | cfg_valid_i/cfg_ready_o         | data: fraction_digits
//
// One number at a time: load, the double-dabble loop (one bit a cycle over
// INT_BITS bits), the sign if negative, IntDigits integer steps, the point,
// then fraction_digits fraction steps. Output stalls hold the emitting step;
// the output register lets the next number load while the final character
// still waits. Reset clears the controller and sets fraction_digits to 2.
// Config writes are always taken.
`timescale 1ns / 1ps

module fixed_to_decimal_text_core #(
  parameter int FRAC_BITS           = f2d_pkg::DEF_FRAC_BITS,
  parameter int INT_BITS            = f2d_pkg::DEF_INT_BITS,
  parameter int MAX_FRACTION_DIGITS = f2d_pkg::DEF_MAX_FRACTION_DIGITS,
  parameter int S_DATA_W            = ((INT_BITS + FRAC_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [S_DATA_W-1:0]           s_axis_tdata_i,  // [INT+FRAC-1:0] value
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [f2d_pkg::CHAR_W-1:0]    m_axis_tdata_o,  // [7:0] character
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [f2d_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int TotalBits = INT_BITS + FRAC_BITS;

  f2d_pkg::f2d_cmd_t cmd;
  f2d_pkg::f2d_sts_t sts;

  // Always take config words; by contract writes land only while idle, which the core does not enforce.
  assign cfg_ready_o = 1'b1;

  f2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Drop the pad bits above the value.
  f2d_datapath #(
    .FRAC_BITS           (FRAC_BITS),
    .INT_BITS            (INT_BITS),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (s_axis_tdata_i[TotalBits-1:0]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ----- design/f2d_checker.sv -----
// Port-level checker for the fixed-to-decimal text core, bound to the top.
// Depends on f2d_pkg and fixed_to_decimal_text_core_macros.svh.
`timescale 1ns / 1ps
`include "fixed_to_decimal_text_core_macros.svh"

module f2d_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_tvalid_i,
  input logic                       s_tready_i,
  input logic                       m_tvalid_i,
  input logic                       m_tready_i,
  input logic [f2d_pkg::CHAR_W-1:0] m_tdata_i,
  input logic                       m_tlast_i
);

  // A stalled output word holds.
  `F2D_ASSERT_NXT(a_out_hold, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i))

  // A loaded number keeps the input closed while its text is built.
  `F2D_ASSERT_NXT(a_busy_after_load, s_tvalid_i && s_tready_i, !s_tready_i)

  // Only sign, point and digits leave the core.
  `F2D_ASSERT_IMP(a_char_set, m_tvalid_i, (m_tdata_i == f2d_pkg::CHAR_MINUS) || (m_tdata_i == f2d_pkg::CHAR_DOT) || ((m_tdata_i >= f2d_pkg::CHAR_ZERO) && (m_tdata_i <= f2d_pkg::CHAR_NINE)))

  // The text never ends on the sign.
  `F2D_ASSERT_IMP(a_last_not_sign, m_tvalid_i && m_tlast_i, m_tdata_i != f2d_pkg::CHAR_MINUS)

endmodule

bind fixed_to_decimal_text_core f2d_checker u_f2d_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o)
);

// ----- sim/fixed_to_decimal_text_core_tb.sv -----
// Self-checking bench for fixed_to_decimal_text_core: drives Q32.16 values, predicts the
// ASCII text of each one and checks every output word in order. Depends on f2d_pkg.
`timescale 1ns / 1ps

module fixed_to_decimal_text_core_tb;

  localparam int DEF_INT_BITS            = f2d_pkg::DEF_INT_BITS;
  localparam int DEF_FRAC_BITS           = f2d_pkg::DEF_FRAC_BITS;
  localparam int DEF_MAX_FRACTION_DIGITS = f2d_pkg::DEF_MAX_FRACTION_DIGITS;
  localparam int CHAR_W                  = f2d_pkg::CHAR_W;
  localparam int CFG_W                   = f2d_pkg::CFG_W;

  localparam int VALUE_W      = DEF_INT_BITS + DEF_FRAC_BITS;
  localparam int DRAIN_CYCLES = 80;       // worst-case latency of one number, with margin
  localparam int HOLD_CYCLES  = 400;      // long output stall for the fill-up test
  localparam int CYCLE_LIMIT  = 800000;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              last;
  } text_char_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [VALUE_W-1:0]   s_axis_tdata_i;   // [47:0] value
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [CHAR_W-1:0]    m_axis_tdata_o;   // [7:0] character
  logic                 m_axis_tlast_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i;

  // Expected characters, oldest first, and the bench's copy of the register.
  text_char_t           text_q[$];
  text_char_t           want;
  logic [CFG_W-1:0]     frac_digits_model;
  int                   errors;
  int                   cycles;
  bit                   idle_en;
  bit                   hold_req;
  int                   hold_left;

  fixed_to_decimal_text_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Append the text of one number to the expected queue: sign, integer digits
  // (at least one), the point, then truncated fraction digits by exact times-ten steps.
  function automatic void render_decimal(input logic [VALUE_W-1:0] value,
                                         input logic [CFG_W-1:0] ndig);
    logic                   neg;
    logic [VALUE_W-1:0]     mag;
    logic [DEF_INT_BITS-1:0] ipart;
    logic [DEF_FRAC_BITS-1:0] frac;
    logic [DEF_FRAC_BITS+3:0] scaled;
    logic [3:0]             digs[12];
    int                     nint;
    int                     count;
    text_char_t             w;
    neg   = value[VALUE_W-1];
    mag   = neg ? (~value + 1'b1) : value;
    ipart = mag[VALUE_W-1:DEF_FRAC_BITS];
    frac  = mag[DEF_FRAC_BITS-1:0];
    count = (ndig > DEF_MAX_FRACTION_DIGITS) ? DEF_MAX_FRACTION_DIGITS : int'(ndig);
    w.last = 1'b0;
    if (neg) begin
      w.chr = f2d_pkg::CHAR_MINUS;
      text_q.push_back(w);
    end
    nint = 0;
    do begin
      digs[nint] = 4'(ipart % 10);
      ipart      = ipart / 10;
      nint++;
    end while (ipart != 0);
    for (int k = nint - 1; k >= 0; k--) begin
      w.chr = f2d_pkg::CHAR_ZERO + CHAR_W'(digs[k]);
      text_q.push_back(w);
    end
    w.chr = f2d_pkg::CHAR_DOT;
    text_q.push_back(w);
    for (int k = 0; k < count; k++) begin
      scaled = {4'd0, frac} * 10;
      w.chr  = f2d_pkg::CHAR_ZERO + CHAR_W'(scaled[DEF_FRAC_BITS+3:DEF_FRAC_BITS]);
      frac   = scaled[DEF_FRAC_BITS-1:0];
      text_q.push_back(w);
    end
    text_q[text_q.size()-1].last = 1'b1;
  endfunction

  // Random value, shaped toward digit-count boundaries, pure fractions and extremes.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [63:0]        wide;
    logic [31:0]        r;
    logic [VALUE_W-1:0] v;
    longint             p;
    int                 k;
    wide = {$urandom, $urandom};
    r    = $urandom;
    case ($urandom_range(4))
      0: begin
        v = wide[VALUE_W-1:0];
      end
      1: begin
        v = {32'd0, r[15:0]};
      end
      2: begin
        k = $urandom_range(9);
        p = 1;
        repeat (k) p = p * 10;
        if (r[16]) p = p - 1;
        v = {p[31:0], r[15:0]};
      end
      3: begin
        v = {22'd0, r[25:16], r[15:0]};
      end
      default: begin
        v = {1'b0, {(VALUE_W-1){1'b1}}} - {38'd0, r[9:0]};
      end
    endcase
    if (r[31]) v = ~v + 1'b1;
    return v;
  endfunction

  // Offer one word on the input, with random idle cycles ahead of it.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    if (idle_en) begin
      while ($urandom_range(99) < 23) begin
        @(negedge clk_i);
        s_axis_tvalid_i = 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    render_decimal(value, frac_digits_model);
  endtask

  // Drop the input, wait until every expected word has come, then let the core go idle.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (text_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_fraction_digits(input logic [CFG_W-1:0] n);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = n;
    do @(posedge clk_i); while (!cfg_ready_o);
    frac_digits_model = n;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Reset value of the register: two fraction digits, no write yet.
  task automatic test_reset_default();
    send_value(48'h0000_0000_0000);
    send_value(48'h0000_0001_8000);               // 1.5
    send_value(48'hFFFF_FFFE_8000);               // -1.5
    send_value(48'hFFFF_FFFF_FFFF);               // tiny negative, prints "-0.00"
    send_value(48'h0000_0000_4000);               // zero integer part
    settle();
  endtask

  // Field extremes at both ends of the digit count.
  task automatic test_extremes();
    write_fraction_digits(4'd0);                  // text ends on the point
    send_value(48'h0000_0000_0000);
    send_value(48'h7FFF_FFFF_FFFF);
    send_value(48'h8000_0000_0000);               // most negative, integer part 2^31
    send_value(48'hFFFF_FFFF_FFFF);
    settle();
    write_fraction_digits(4'd15);
    send_value(48'h0000_0000_FFFF);
    send_value(48'h7FFF_FFFF_FFFF);
    send_value(48'h8000_0000_0000);
    send_value(48'hFFFF_FFFF_FFFF);
    send_value(48'h0000_0001_0000);
    send_value(48'hFFFF_FFFF_0000);
    send_value(48'h0000_0000_0001);
    send_value(48'h3B9A_CA00_0000);               // 10^9, ten integer digits
    send_value(48'hC465_3600_8000);               // -(10^9 - 0.5)
    settle();
  endtask

  // Random values over several digit counts; one phase runs without idling.
  task automatic test_random_sweep();
    logic [CFG_W-1:0] digits;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: digits = 4'd0;
        1: digits = 4'd15;
        2: digits = 4'd2;
        default: digits = CFG_W'($urandom_range(15));
      endcase
      write_fraction_digits(digits);
      idle_en = (ph != 3);
      for (int n = 0; n < 54; n++) send_value(pick_value());
      settle();
    end
    idle_en = 1'b1;
  endtask

  // Hold the output for a long stretch while words keep coming, then pause
  // the input until the backlog has drained and resume.
  task automatic test_output_hold();
    write_fraction_digits(4'd6);
    @(posedge clk_i);
    hold_req = 1'b1;
    for (int n = 0; n < 10; n++) send_value(pick_value());
    settle();
    for (int n = 0; n < 6; n++) send_value(pick_value());
    settle();
  endtask

  // Output side: random stalls, or a counted hold when requested.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      m_axis_tready_i = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready_i = !(idle_en && ($urandom_range(99) < 23));
    end
  end

  // Compare each accepted output word with the oldest expected character.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (text_q.size() == 0) begin
        $error("unexpected word: character %h last %b", m_axis_tdata_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = text_q.pop_front();
        if (m_axis_tdata_o !== want.chr) begin
          $error("character: expected %h actual %h", want.chr, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %b actual %b", want.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    s_axis_tvalid_i   = 1'b0;
    s_axis_tdata_i    = '0;
    m_axis_tready_i   = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    frac_digits_model = f2d_pkg::CFG_RESET;
    errors            = 0;
    cycles            = 0;
    idle_en           = 1'b1;
    hold_req          = 1'b0;
    hold_left         = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_default();
    test_extremes();
    test_random_sweep();
    test_output_hold();

    if (errors == 0 && text_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
